FILE: rtl/buddy_page_allocator_defines.svh
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared concurrent assertion forms clocked on clk_i and gated by rst_ni.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Codes, sequencer states, datapath commands and the status bundle.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOBLK   = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [12:0] PAGE_COUNT_RST = 13'd4096;
  localparam int          REG_PAGE_COUNT = 0;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_A_SCAN, S_U_RD, S_U_LAT, S_U_W1, S_U_W2, S_U_W3,
    S_A_TAKE, S_A_SPLIT, S_A_BUD, S_P_W1, S_P_W2, S_A_FIN, S_F_TST,
    S_M_LOOP, S_M_TST, S_M_U2, S_M_UP, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    C_CLR, C_IDLE, C_DEC, C_A_SCAN, C_U_RD, C_U_LAT, C_U_W1, C_U_W2, C_U_W3,
    C_A_TAKE, C_A_SPLIT, C_A_BUD, C_P_W1, C_P_W2, C_A_FIN, C_F_TST,
    C_M_LOOP, C_M_TST, C_M_U2, C_M_UP, C_DONE
  } cmd_e;

  typedef struct packed {
    logic acc;
    logic op;
    logic clr_last;
    logic lvl_over;
    logic found;
    logic split_more;
    logic bud_ok;
    logic free_bad;
    logic merge_stop;
    logic merge_ok;
    logic out_free;
  } bpa_sts_t;

endpackage

FILE: rtl/buddy_page_allocator.sv
// An allocation scans up from the requested level for a non-empty list, unlinks its head and
// splits it down, pushing each buddy; a free pushes the page, then merges while its buddy is free.
// Each list step reads and writes the page record memories one address at a time.
// One request is in work at a time; the next is taken once its result is registered.
// After reset a clearing pass over all PAGES page records runs before the first request is taken.
// ---------------------------------------------------------------------------
// Buddy page allocator
// Binary buddy allocator over page indices with per-level free lists.
// ---------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int PAGES  = 4096,
  parameter int LEVELS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // req_level[3:0], free_page[15:4]
  input  logic [0:0]  s_axis_tuser,   // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // block_page[11:0], zero[15:12]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bpa_pkg::*;

  cmd_e     cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  bpa_dp #(.PAGES(PAGES), .LEVELS(LEVELS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

endmodule

FILE: rtl/bpa_ram.sv
// ---------------------------------------------------------------------------
// Buddy page allocator generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bpa_ctrl.sv
// ---------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences the clearing pass, list scan, unlink, push, split and merge steps.
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_defines.svh"

module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::bpa_sts_t sts_i,
  output bpa_pkg::cmd_e     cmd_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = C_IDLE;
    case (state_q)
      S_CLR: begin
        cmd_o = C_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o = C_IDLE;
        if (sts_i.acc) state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o   = C_DEC;
        state_d = (sts_i.op == OP_FREE) ? S_F_TST : S_A_SCAN;
      end
      S_A_SCAN: begin
        cmd_o = C_A_SCAN;
        if (sts_i.lvl_over) begin
          state_d = S_DONE;
        end else if (sts_i.found) begin
          ret_d   = S_A_TAKE;
          state_d = S_U_RD;
        end
      end
      S_U_RD: begin
        cmd_o   = C_U_RD;
        state_d = S_U_LAT;
      end
      S_U_LAT: begin
        cmd_o   = C_U_LAT;
        state_d = S_U_W1;
      end
      S_U_W1: begin
        cmd_o   = C_U_W1;
        state_d = S_U_W2;
      end
      S_U_W2: begin
        cmd_o   = C_U_W2;
        state_d = S_U_W3;
      end
      S_U_W3: begin
        cmd_o   = C_U_W3;
        state_d = ret_q;
      end
      S_A_TAKE: begin
        cmd_o   = C_A_TAKE;
        state_d = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        cmd_o   = C_A_SPLIT;
        state_d = sts_i.split_more ? S_A_BUD : S_A_FIN;
      end
      S_A_BUD: begin
        cmd_o = C_A_BUD;
        if (sts_i.bud_ok) begin
          ret_d   = S_A_SPLIT;
          state_d = S_P_W1;
        end else begin
          state_d = S_A_SPLIT;
        end
      end
      S_P_W1: begin
        cmd_o   = C_P_W1;
        state_d = S_P_W2;
      end
      S_P_W2: begin
        cmd_o   = C_P_W2;
        state_d = ret_q;
      end
      S_A_FIN: begin
        cmd_o   = C_A_FIN;
        state_d = S_DONE;
      end
      S_F_TST: begin
        cmd_o = C_F_TST;
        if (sts_i.free_bad) begin
          state_d = S_DONE;
        end else begin
          ret_d   = S_M_LOOP;
          state_d = S_P_W1;
        end
      end
      S_M_LOOP: begin
        cmd_o   = C_M_LOOP;
        state_d = sts_i.merge_stop ? S_DONE : S_M_TST;
      end
      S_M_TST: begin
        cmd_o = C_M_TST;
        if (sts_i.merge_ok) begin
          ret_d   = S_M_U2;
          state_d = S_U_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_M_U2: begin
        cmd_o   = C_M_U2;
        ret_d   = S_M_UP;
        state_d = S_U_RD;
      end
      S_M_UP: begin
        cmd_o   = C_M_UP;
        ret_d   = S_M_LOOP;
        state_d = S_P_W1;
      end
      S_DONE: begin
        cmd_o = C_DONE;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `BPA_ASSERT_NEXT(a_acc_decode, sts_i.acc, state_q == S_DEC, "accepted request not decoded")
  `BPA_ASSERT_NEXT(a_unlink_ret, state_q == S_U_W3, state_q == $past(ret_q), "bad unlink return")
  `BPA_ASSERT_NOW(a_push_ret, state_q == S_P_W2, ret_q == S_A_SPLIT || ret_q == S_M_LOOP, "bad push return")

endmodule

FILE: rtl/bpa_dp.sv
// ---------------------------------------------------------------------------
// Buddy page allocator datapath
// Page record memories, list heads, work registers and the bus ports.
// ---------------------------------------------------------------------------
module bpa_dp #(
  parameter int PAGES  = 4096,
  parameter int LEVELS = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::cmd_e     cmd_i,
  output bpa_pkg::bpa_sts_t sts_o,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,
  output logic [1:0]        m_axis_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bpa_pkg::*;

  localparam int AW = $clog2(PAGES);
  localparam int PW = AW + 1;
  localparam int HW = $clog2(LEVELS);
  localparam int LW = $clog2(LEVELS + 1);
  localparam logic [PW-1:0] NIL = {PW{1'b1}};

  logic [AW-1:0] cur_q, oth_q, unl_q, psh_q, cnt_q;
  logic [PW-1:0] pr_q, nx_q, n_q;
  logic [LW-1:0] lvl_q;
  logic [HW-1:0] tgt_q;
  logic          op_q, bad_q;
  logic [1:0]    st_q;
  logic [PW-1:0] heads_q [LEVELS];
  logic [12:0]   page_count_q;
  logic          out_valid_q;
  logic [1:0]    out_st_q;
  logic [11:0]   out_page_q;

  logic [AW-1:0] waddr, raddr;
  logic          prev_we, next_we, lvl_we, free_we;
  logic [PW-1:0] prev_wd, next_wd, prev_rd, next_rd;
  logic [HW-1:0] lvl_wd, lvl_rd;
  logic          free_wd, free_rd;

  logic [HW-1:0] lvl_idx;
  logic          lvl_ok;
  logic [PW-1:0] head_cur;
  logic [AW-1:0] bud, lo_pg;
  logic          bud_in, bud_cnt_ok, in_list, acc, out_free;
  logic [3:0]    in_level;
  logic [11:0]   in_page;
  logic          in_big;

  assign lvl_idx    = lvl_q[HW-1:0];
  assign lvl_ok     = 32'(lvl_q) < LEVELS;
  assign head_cur   = lvl_ok ? heads_q[lvl_idx] : NIL;
  assign bud        = cur_q ^ (AW'(1) << lvl_q);
  assign bud_in     = (32'(lvl_q) < AW) && (32'(bud) < PAGES);
  assign bud_cnt_ok = 32'(bud) < 32'(page_count_q);
  assign lo_pg      = (cur_q < oth_q) ? cur_q : oth_q;
  assign in_list    = (prev_rd != NIL) || (head_cur == {1'b0, oth_q});
  assign in_level   = s_axis_tdata[3:0];
  assign in_page    = s_axis_tdata[15:4];
  assign in_big     = 32'(in_level) >= LEVELS;

  assign s_axis_tready = (cmd_i == C_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_page_q};
  assign m_axis_tuser  = out_st_q;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {19'd0, page_count_q};

  always_comb begin
    sts_o            = '0;
    sts_o.acc        = acc;
    sts_o.op         = op_q;
    sts_o.clr_last   = 32'(cnt_q) == PAGES - 1;
    sts_o.lvl_over   = !lvl_ok;
    sts_o.found      = head_cur != NIL;
    sts_o.split_more = lvl_q > LW'(tgt_q);
    sts_o.bud_ok     = bud_in;
    sts_o.free_bad   = bad_q || free_rd;
    sts_o.merge_stop = (32'(lvl_q) >= LEVELS - 1) || !bud_in || !bud_cnt_ok;
    sts_o.merge_ok   = free_rd && (lvl_rd == lvl_idx) && in_list;
    sts_o.out_free   = out_free;
  end

  always_comb begin
    waddr   = cur_q;
    raddr   = cur_q;
    prev_we = 1'b0;
    next_we = 1'b0;
    lvl_we  = 1'b0;
    free_we = 1'b0;
    prev_wd = NIL;
    next_wd = NIL;
    lvl_wd  = lvl_idx;
    free_wd = 1'b1;
    case (cmd_i)
      C_CLR: begin
        waddr   = cnt_q;
        prev_we = 1'b1;
        next_we = 1'b1;
        lvl_we  = 1'b1;
        free_we = 1'b1;
        lvl_wd  = '0;
        free_wd = 1'b0;
      end
      C_U_RD: raddr = unl_q;
      C_U_W1: begin
        waddr   = pr_q[AW-1:0];
        next_we = pr_q != NIL;
        next_wd = nx_q;
      end
      C_U_W2: begin
        waddr   = nx_q[AW-1:0];
        prev_we = nx_q != NIL;
        prev_wd = pr_q;
      end
      C_U_W3: begin
        waddr   = unl_q;
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      C_P_W1: begin
        waddr   = psh_q;
        prev_we = 1'b1;
        next_we = 1'b1;
        next_wd = head_cur;
        lvl_we  = 1'b1;
        free_we = 1'b1;
      end
      C_P_W2: begin
        waddr   = n_q[AW-1:0];
        prev_we = n_q != NIL;
        prev_wd = {1'b0, psh_q};
      end
      C_A_TAKE: begin
        free_we = 1'b1;
        free_wd = 1'b0;
      end
      C_A_FIN: begin
        lvl_we = 1'b1;
        lvl_wd = tgt_q;
      end
      C_M_LOOP: raddr = bud;
      default: begin
        raddr = cur_q;
      end
    endcase
  end

  bpa_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(waddr), .wdata_i(prev_wd), .raddr_i(raddr),
    .rdata_o(prev_rd)
  );
  bpa_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(waddr), .wdata_i(next_wd), .raddr_i(raddr),
    .rdata_o(next_rd)
  );
  bpa_ram #(.WIDTH(HW), .DEPTH(PAGES)) u_lvl (
    .clk_i, .we_i(lvl_we), .waddr_i(waddr), .wdata_i(lvl_wd), .raddr_i(raddr),
    .rdata_o(lvl_rd)
  );
  bpa_ram #(.WIDTH(1), .DEPTH(PAGES)) u_free (
    .clk_i, .we_i(free_we), .waddr_i(waddr), .wdata_i(free_wd), .raddr_i(raddr),
    .rdata_o(free_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      page_count_q <= PAGE_COUNT_RST;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        heads_q[i] <= NIL;
      end
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        page_count_q <= pwdata[12:0];
      end
      if (cmd_i == C_CLR) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i == C_U_W1 && pr_q == NIL && lvl_ok && head_cur == {1'b0, unl_q}) begin
        heads_q[lvl_idx] <= nx_q;
      end
      if (cmd_i == C_P_W1 && lvl_ok) begin
        heads_q[lvl_idx] <= {1'b0, psh_q};
      end
      if (cmd_i == C_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q  <= s_axis_tuser[0];
      lvl_q <= in_big ? LW'(LEVELS) : LW'(in_level);
      tgt_q <= HW'(in_level);
      cur_q <= AW'({20'd0, in_page});
      bad_q <= (32'(in_page) >= PAGES) || ({1'b0, in_page} >= page_count_q);
    end
    case (cmd_i)
      C_A_SCAN: begin
        if (!lvl_ok) begin
          st_q <= ST_NOBLK;
        end else if (head_cur != NIL) begin
          cur_q <= head_cur[AW-1:0];
          unl_q <= head_cur[AW-1:0];
        end else begin
          lvl_q <= lvl_q + LW'(1);
        end
      end
      C_U_LAT: begin
        pr_q <= prev_rd;
        nx_q <= next_rd;
      end
      C_P_W1:    n_q <= head_cur;
      C_A_SPLIT: if (lvl_q > LW'(tgt_q)) lvl_q <= lvl_q - LW'(1);
      C_A_BUD:   psh_q <= bud;
      C_A_FIN:   st_q <= ST_ALLOC;
      C_F_TST: begin
        st_q  <= (bad_q || free_rd) ? ST_IGNORED : ST_FREED;
        lvl_q <= LW'(lvl_rd);
        psh_q <= cur_q;
      end
      C_M_LOOP: oth_q <= bud;
      C_M_TST:  unl_q <= cur_q;
      C_M_U2:   unl_q <= oth_q;
      C_M_UP: begin
        cur_q <= lo_pg;
        psh_q <= lo_pg;
        lvl_q <= lvl_q + LW'(1);
      end
      C_DONE: begin
        if (out_free) begin
          out_st_q   <= st_q;
          out_page_q <= (st_q == ST_ALLOC) ? 12'(32'(cur_q)) : 12'd0;
        end
      end
      default: begin
        n_q <= n_q;
      end
    endcase
  end

endmodule
